// ===== src/ole_pkg.sv =====
// ole_pkg: item types, command and status codes, and the cell control bundle
// for the ordered list engine. No dependencies; used by every module under src.
package ole_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 7;

    // command codes
    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_INSERT = 2'd2;
    localparam logic [1:0] CMD_REMOVE = 2'd3;

    // status codes
    localparam logic [1:0] STATUS_DONE     = 2'd0;
    localparam logic [1:0] STATUS_NOCHANGE = 2'd1;
    localparam logic [1:0] STATUS_FULL     = 2'd2;
    localparam logic [1:0] STATUS_EMPTY    = 2'd3;

    typedef struct packed {
        logic [1:0]                 command;
        logic signed [VALUE_W-1:0]  value;
    } cmd_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  popped_value;
        logic [1:0]                 status;
        logic [COUNT_W-1:0]         entry_count;
    } rsp_item_t;

    // broadcast from the top level to every cell during the apply cycle
    typedef struct packed {
        logic                       insert_en;
        logic                       remove_en;
        logic                       force_stop;
        logic signed [VALUE_W-1:0]  value;
    } cell_ctrl_t;

endpackage

// ===== src/ole_cell.sv =====
// ole_cell: one list slot; holds an entry, its registered compare flags, and
// takes part in the walk chain and the shift. Depends on ole_pkg.
module ole_cell (
    input  logic                               clk,
    input  logic                               load_cmp,
    input  logic signed [ole_pkg::VALUE_W-1:0] cmp_value,
    input  ole_pkg::cell_ctrl_t                ctrl,
    input  logic                               occupied,
    input  logic signed [ole_pkg::VALUE_W-1:0] left_entry,
    input  logic signed [ole_pkg::VALUE_W-1:0] right_entry,
    input  logic                               before_in,
    output logic                               before_out,
    output logic signed [ole_pkg::VALUE_W-1:0] entry,
    output logic                               eq_hit
);
    import ole_pkg::*;

    logic signed [VALUE_W-1:0] entry_reg;
    logic signed [VALUE_W-1:0] entry_next;
    logic                      lt_reg;
    logic                      eq_reg;
    logic                      stop;
    logic                      here;

    // compare against the incoming item's value when it is taken
    always_ff @(posedge clk)
    begin
        if (load_cmp)
        begin
            lt_reg <= (entry_reg < cmp_value);
            eq_reg <= (entry_reg == cmp_value);
        end
    end

    // walk chain: the first cell that stops is the position
    assign stop       = ctrl.force_stop | ~occupied | ~lt_reg;
    assign here       = stop & ~before_in;
    assign before_out = before_in | stop;
    assign eq_hit     = here & occupied & eq_reg;

    // shift right to open a gap, shift left to close one
    always_comb
    begin
        priority if (ctrl.insert_en && here)
            entry_next = ctrl.value;
        else if (ctrl.insert_en && before_in)
            entry_next = left_entry;
        else if (ctrl.remove_en && (here || before_in))
            entry_next = right_entry;
        else
            entry_next = entry_reg;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== src/ordered_list_engine_top.sv =====
// ordered_list_engine_top: bounded ordered list built as a row of ole_cell
// slots with command handshake, length counter and result register.
// Depends on ole_pkg and ole_cell.
// The result is registered in the apply state, which follows accept and waits while an
// earlier result is untaken; new commands are taken only when idle. Each cell registers
// its compare at accept; the walk then ripples through the cell row and the shift commits.
// Reset (rst_n, async low) clears the length and handshake state; entries are not cleared.
module ordered_list_engine_top #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  ole_pkg::cmd_item_t cmd_item,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output ole_pkg::rsp_item_t rsp_item
);
    import ole_pkg::*;

    localparam int unsigned LEN_W = $clog2(CAPACITY + 1);

    typedef enum logic {
        ST_IDLE,
        ST_APPLY
    } state_t;

    state_t                    state_reg;
    logic [1:0]                command_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic [LEN_W-1:0]          len_reg;
    logic                      rsp_valid_reg;
    rsp_item_t                 rsp_reg;

    logic                      accept;
    logic                      apply_fire;
    logic                      full;
    logic                      empty;
    logic                      eq_found;
    logic                      do_insert;
    logic                      do_remove;
    logic [1:0]                status_next;
    logic [LEN_W-1:0]          len_next;
    logic [LEN_W+COUNT_W-1:0]  count_wide;
    cell_ctrl_t                ctrl;

    logic [CAPACITY-1:0]       occupied;
    logic [CAPACITY-1:0]       eq_hit;
    logic [CAPACITY:0]         stop_seen;
    logic signed [VALUE_W-1:0] entries [CAPACITY];

    assign cmd_ready  = (state_reg == ST_IDLE);
    assign accept     = cmd_valid & cmd_ready;
    assign apply_fire = (state_reg == ST_APPLY) & (~rsp_valid_reg | rsp_ready);

    assign full     = (len_reg == LEN_W'(CAPACITY));
    assign empty    = (len_reg == '0);
    assign eq_found = |eq_hit;

    // decide what the command does with the walk result
    always_comb
    begin
        do_insert   = 1'b0;
        do_remove   = 1'b0;
        status_next = STATUS_DONE;
        unique case (command_reg)
            CMD_PUSH:
            begin
                if (full)
                    status_next = STATUS_FULL;
                else
                    do_insert = 1'b1;
            end
            CMD_POP:
            begin
                if (empty)
                    status_next = STATUS_EMPTY;
                else
                    do_remove = 1'b1;
            end
            CMD_INSERT:
            begin
                if (full)
                    status_next = STATUS_FULL;
                else if (eq_found)
                    status_next = STATUS_NOCHANGE;
                else
                    do_insert = 1'b1;
            end
            default:
            begin
                if (eq_found)
                    do_remove = 1'b1;
                else
                    status_next = STATUS_NOCHANGE;
            end
        endcase
    end

    always_comb
    begin
        priority if (do_insert)
            len_next = len_reg + LEN_W'(1);
        else if (do_remove)
            len_next = len_reg - LEN_W'(1);
        else
            len_next = len_reg;
    end

    assign count_wide = {{COUNT_W{1'b0}}, len_next};

    // control broadcast to the cells
    assign ctrl.insert_en  = apply_fire & do_insert;
    assign ctrl.remove_en  = apply_fire & do_remove;
    assign ctrl.force_stop = (command_reg == CMD_PUSH) | (command_reg == CMD_POP);
    assign ctrl.value      = value_reg;

    // row of cells
    assign stop_seen[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [VALUE_W-1:0] left_w;
            logic signed [VALUE_W-1:0] right_w;

            assign occupied[gi] = (LEN_W'(gi) < len_reg);

            if (gi == 0)
            begin : g_first
                assign left_w = value_reg;
            end
            else
            begin : g_inner_l
                assign left_w = entries[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_w = entries[gi];
            end
            else
            begin : g_inner_r
                assign right_w = entries[gi+1];
            end

            ole_cell u_cell (
                .clk         (clk),
                .load_cmp    (accept),
                .cmp_value   (cmd_item.value),
                .ctrl        (ctrl),
                .occupied    (occupied[gi]),
                .left_entry  (left_w),
                .right_entry (right_w),
                .before_in   (stop_seen[gi]),
                .before_out  (stop_seen[gi+1]),
                .entry       (entries[gi]),
                .eq_hit      (eq_hit[gi])
            );
        end
    endgenerate

    // sequencer, length counter and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (apply_fire)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                        state_reg <= ST_APPLY;
                end
                ST_APPLY:
                begin
                    if (apply_fire)
                    begin
                        len_reg   <= len_next;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            command_reg <= cmd_item.command;
            value_reg   <= cmd_item.value;
        end
        if (apply_fire)
        begin
            rsp_reg.popped_value <= (command_reg == CMD_POP && do_remove) ? entries[0] : '0;
            rsp_reg.status       <= status_next;
            rsp_reg.entry_count  <= count_wide[COUNT_W-1:0];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_reg;

    // checks
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(CAPACITY))
        else $error("list length above capacity");

    a_rsp_from_apply: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_APPLY))
        else $error("result raised without an apply cycle");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.status == STATUS_FULL) |-> full)
        else $error("full status while list is not full");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.status == STATUS_EMPTY) |->
            (rsp_reg.popped_value == '0 && empty))
        else $error("empty status with data or entries");

endmodule
